/* hdl/vfd_digit_scan_serializer_core_macros.svh */
// Assertion macros shared by the digit scan serializer.
`ifndef VFD_DIGIT_SCAN_SERIALIZER_CORE_MACROS_SVH
`define VFD_DIGIT_SCAN_SERIALIZER_CORE_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define VDSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define VDSS_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (nxt)) else $error(msg);

`endif

/* hdl/vdss_pkg.sv */
// Shared constants, types and the segment decoder of the digit scan serializer.
package vdss_pkg;

    localparam int DIGITS_DEF = 4;
    localparam int SEG_BITS   = 8;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [SEG_BITS-1:0] seg_decode(input logic [3:0] value);
        logic [SEG_BITS-1:0] pattern;
        unique case (value)
            4'd0:    pattern = 8'hFE;
            4'd1:    pattern = 8'h50;
            4'd2:    pattern = 8'hB5;
            4'd3:    pattern = 8'h75;
            4'd4:    pattern = 8'h59;
            4'd5:    pattern = 8'h6D;
            4'd6:    pattern = 8'hEF;
            4'd7:    pattern = 8'h54;
            4'd8:    pattern = 8'hFD;
            4'd9:    pattern = 8'h7D;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

/* hdl/vdss_front.sv */
// Front end: accepts words, keeps the digit patterns and issues scan jobs.
module vdss_front #(
    parameter int DIGITS = vdss_pkg::DIGITS_DEF,
    parameter int PW     = (DIGITS > 1) ? $clog2(DIGITS) : 1,
    parameter int EW     = PW + vdss_pkg::SEG_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_action,
    input  logic [1:0]       i_digit_index,
    input  logic [3:0]       i_digit_value,
    input  vdss_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output logic [EW-1:0]    o_entry
);
    import vdss_pkg::*;

    logic [SEG_BITS-1:0] r_seg [DIGITS];
    logic [PW-1:0]       r_pos;
    logic [PW-1:0]       n_pos;
    logic                w_accept;
    logic [SEG_BITS-1:0] w_pattern;

    assign o_in_ready = !i_q_stat.full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = w_accept && (i_action == ACT_TICK);
    assign w_pattern  = seg_decode(i_digit_value);
    assign o_entry    = {r_pos, r_seg[r_pos]};

    always_comb begin
        if (r_pos == PW'(DIGITS - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            for (int k = 0; k < DIGITS; k++) begin
                r_seg[k] <= '0;
            end
        end else begin
            if (o_push) begin
                r_pos <= n_pos;
            end
            for (int k = 0; k < DIGITS; k++) begin
                if (w_accept && (i_action == ACT_STORE) && (int'(i_digit_index) == k)) begin
                    r_seg[k] <= w_pattern;
                end
            end
        end
    end

endmodule

/* hdl/vdss_queue.sv */
// Two-entry queue of scan jobs between the front and back ends.
module vdss_queue #(
    parameter int EW = vdss_pkg::SEG_BITS + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [EW-1:0]     i_data,
    input  logic              i_pop,
    output logic [EW-1:0]     o_data,
    output vdss_pkg::t_q_stat o_stat
);
    import vdss_pkg::*;

    logic [EW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_data       = r_mem[r_rp];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* hdl/vdss_back.sv */
// Back end: serializes one scan job into grid, segment and load words.
module vdss_back #(
    parameter int DIGITS = vdss_pkg::DIGITS_DEF,
    parameter int PW     = (DIGITS > 1) ? $clog2(DIGITS) : 1,
    parameter int EW     = PW + vdss_pkg::SEG_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [EW-1:0]     i_entry,
    input  vdss_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_data_bit,
    output logic              o_shift_strobe,
    output logic              o_load_strobe,
    output logic              o_blank_level,
    output logic              o_last
);
    import vdss_pkg::*;

    localparam int RUN_LEN = DIGITS + SEG_BITS + 1;
    localparam int CW      = $clog2(RUN_LEN);

    logic                r_busy;
    logic [CW-1:0]       r_cnt;
    logic [PW-1:0]       r_pos;
    logic [SEG_BITS-1:0] r_pat;
    logic                r_out_valid;
    logic                r_data;
    logic                r_shift;
    logic                r_load;
    logic                r_blank;
    logic                r_last;
    logic                n_data;
    logic                n_shift;
    logic                n_load;
    logic                n_blank;
    logic                n_last;
    logic                w_out_free;
    logic                w_fire;
    logic                w_done;
    logic [CW-1:0]       w_seg_off;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_busy && w_out_free;
    assign w_done     = w_fire && (r_cnt == CW'(RUN_LEN - 1));
    assign o_pop      = !i_q_stat.empty && (!r_busy || w_done);
    assign w_seg_off  = r_cnt - CW'(DIGITS);

    always_comb begin
        priority if (r_cnt < CW'(DIGITS)) begin
            n_data  = (r_cnt == CW'(r_pos));
            n_shift = 1'b1;
            n_load  = 1'b0;
            n_blank = 1'b1;
            n_last  = 1'b0;
        end else if (r_cnt < CW'(DIGITS + SEG_BITS)) begin
            n_data  = r_pat[w_seg_off[2:0]];
            n_shift = 1'b1;
            n_load  = 1'b0;
            n_blank = 1'b1;
            n_last  = 1'b0;
        end else begin
            n_data  = 1'b0;
            n_shift = 1'b0;
            n_load  = 1'b1;
            n_blank = 1'b0;
            n_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_cnt       <= w_done ? '0 : r_cnt + CW'(1);
                if (w_done) begin
                    r_busy <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_pos, r_pat} <= i_entry;
        end
        if (w_fire) begin
            r_data  <= n_data;
            r_shift <= n_shift;
            r_load  <= n_load;
            r_blank <= n_blank;
            r_last  <= n_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_bit     = r_data;
    assign o_shift_strobe = r_shift;
    assign o_load_strobe  = r_load;
    assign o_blank_level  = r_blank;
    assign o_last         = r_last;

endmodule

/* hdl/vfd_digit_scan_serializer_core.sv */
// A tick word is written into the job queue, then popped into the back end, which registers its first output word.
// A tick gives DIGITS + 9 words, one a cycle while the receiver is ready.
// Store words are accepted whenever the job queue is not full; the back-end serializer counter sets the tick rate.
// A two-entry job queue lets the input side run ahead of the output side.
// Synchronous active-low reset clears all digit patterns, the scan position and the queue.
`include "vfd_digit_scan_serializer_core_macros.svh"
module vfd_digit_scan_serializer_core #(
    parameter int DIGITS = vdss_pkg::DIGITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_action,
    input  logic [1:0] i_digit_index,
    input  logic [3:0] i_digit_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_data_bit,
    output logic       o_shift_strobe,
    output logic       o_load_strobe,
    output logic       o_blank_level,
    output logic       o_last
);
    import vdss_pkg::*;

    localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int EW = PW + SEG_BITS;

    logic          w_push;
    logic          w_pop;
    logic [EW-1:0] w_front_entry;
    logic [EW-1:0] w_back_entry;
    t_q_stat       w_q_stat;
    logic          w_out_take;
    logic          w_kind_ok;

    vdss_front #(
        .DIGITS(DIGITS),
        .PW    (PW),
        .EW    (EW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_digit_index(i_digit_index),
        .i_digit_value(i_digit_value),
        .i_q_stat     (w_q_stat),
        .o_push       (w_push),
        .o_entry      (w_front_entry)
    );

    vdss_queue #(
        .EW(EW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_front_entry),
        .i_pop  (w_pop),
        .o_data (w_back_entry),
        .o_stat (w_q_stat)
    );

    vdss_back #(
        .DIGITS(DIGITS),
        .PW    (PW),
        .EW    (EW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (w_back_entry),
        .i_q_stat      (w_q_stat),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_bit    (o_data_bit),
        .o_shift_strobe(o_shift_strobe),
        .o_load_strobe (o_load_strobe),
        .o_blank_level (o_blank_level),
        .o_last        (o_last)
    );

    assign w_out_take = o_out_valid && i_out_ready;
    assign w_kind_ok  = (o_load_strobe == o_last) && (o_shift_strobe != o_load_strobe)
                        && (o_blank_level == o_shift_strobe);

    `VDSS_ASSERT(a_q_stat_sane, !(w_q_stat.full && w_q_stat.empty), "queue both full and empty")
    `VDSS_ASSERT(a_load_is_last, !o_out_valid || w_kind_ok, "bad word kind")
    `VDSS_ASSERT_NEXT(a_run_gapless, w_out_take && !o_last, o_out_valid, "gap inside a scan run")

endmodule

/* tb/vfd_digit_scan_serializer_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the VFD digit scan serializer core.
module vfd_digit_scan_serializer_core_test;
    import vdss_pkg::*;

    localparam int DIGITS       = DIGITS_DEF;
    localparam int RANDOM_ITEMS = 435;
    localparam int MAX_GAP      = 17;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic data_bit;
        logic shift;
        logic load;
        logic blank;
        logic last;
    } t_scan_word;

    typedef struct packed {
        logic                action;
        logic [1:0]          index;
        logic [3:0]          value;
        logic                typed;
        logic [DIGITS-1:0]   grid;
        logic [SEG_BITS-1:0] seg;
    } t_digit_cmd;

    localparam logic [SEG_BITS-1:0] SEG_LUT [0:9] = '{
        8'hFE, 8'h50, 8'hB5, 8'h75, 8'h59, 8'h6D, 8'hEF, 8'h54, 8'hFD, 8'h7D
    };

    // Rows with typed set carry the grid and segment bits the tick must send.
    localparam t_digit_cmd DIRECTED [0:24] = '{
        '{ACT_TICK,  2'd0, 4'd0,  1'b1, 4'b0001, 8'h00},
        '{ACT_TICK,  2'd3, 4'd15, 1'b1, 4'b0010, 8'h00},
        '{ACT_STORE, 2'd2, 4'd8,  1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd3, 4'd9,  1'b0, 4'b0000, 8'h00},
        '{ACT_TICK,  2'd0, 4'd0,  1'b1, 4'b0100, 8'hFD},
        '{ACT_TICK,  2'd1, 4'd7,  1'b1, 4'b1000, 8'h7D},
        '{ACT_TICK,  2'd0, 4'd0,  1'b1, 4'b0001, 8'h00},
        '{ACT_STORE, 2'd0, 4'd0,  1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd1, 4'd1,  1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd1, 4'd2,  1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd2, 4'd3,  1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd3, 4'd4,  1'b0, 4'b0000, 8'h00},
        '{ACT_TICK,  2'd2, 4'd12, 1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd0, 4'd5,  1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd1, 4'd6,  1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd2, 4'd7,  1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd3, 4'd15, 1'b0, 4'b0000, 8'h00},
        '{ACT_TICK,  2'd1, 4'd3,  1'b0, 4'b0000, 8'h00},
        '{ACT_TICK,  2'd3, 4'd15, 1'b1, 4'b1000, 8'h00},
        '{ACT_STORE, 2'd0, 4'd10, 1'b0, 4'b0000, 8'h00},
        '{ACT_TICK,  2'd2, 4'd9,  1'b1, 4'b0001, 8'h00},
        '{ACT_STORE, 2'd3, 4'd14, 1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd2, 4'd12, 1'b0, 4'b0000, 8'h00},
        '{ACT_STORE, 2'd1, 4'd13, 1'b0, 4'b0000, 8'h00},
        '{ACT_TICK,  2'd0, 4'd11, 1'b0, 4'b0000, 8'h00}
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       i_action      = ACT_STORE;
    logic [1:0] i_digit_index = 2'd0;
    logic [3:0] i_digit_value = 4'd0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_data_bit;
    logic       o_shift_strobe;
    logic       o_load_strobe;
    logic       o_blank_level;
    logic       o_last;

    logic [SEG_BITS-1:0] digit_patterns [DIGITS];
    int                  scan_pos;
    t_scan_word          pending_scan_words [$];

    int   errors        = 0;
    int   words_checked = 0;
    int   stores_sent   = 0;
    int   ticks_sent    = 0;
    int   idle_cycles   = 0;
    int   rx_hold       = 0;
    logic out_taken     = 1'b0;

    vfd_digit_scan_serializer_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_digit_index  (i_digit_index),
        .i_digit_value  (i_digit_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_bit     (o_data_bit),
        .o_shift_strobe (o_shift_strobe),
        .o_load_strobe  (o_load_strobe),
        .o_blank_level  (o_blank_level),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic queue_scan_run(input logic [DIGITS-1:0] grid,
                                  input logic [SEG_BITS-1:0] pattern);
        t_scan_word w;
        for (int i = 0; i < DIGITS; i++) begin
            w = '{grid[i], 1'b1, 1'b0, 1'b1, 1'b0};
            pending_scan_words.push_back(w);
        end
        for (int i = 0; i < SEG_BITS; i++) begin
            w = '{pattern[i], 1'b1, 1'b0, 1'b1, 1'b0};
            pending_scan_words.push_back(w);
        end
        w = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
        pending_scan_words.push_back(w);
    endtask

    task automatic predict_scan(input t_digit_cmd cmd);
        logic [DIGITS-1:0] grid;
        if (cmd.action == ACT_STORE) begin
            stores_sent++;
            if (cmd.index < DIGITS) begin
                digit_patterns[cmd.index] = (cmd.value <= 9) ? SEG_LUT[cmd.value] : '0;
            end
        end else begin
            ticks_sent++;
            grid = '0;
            grid[scan_pos] = 1'b1;
            if (cmd.typed) begin
                queue_scan_run(cmd.grid, cmd.seg);
            end else begin
                queue_scan_run(grid, digit_patterns[scan_pos]);
            end
            scan_pos = (scan_pos + 1) % DIGITS;
        end
    endtask

    function automatic int draw_gap(input int n);
        return ((n % 90) < 25) ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic send_cmd(input t_digit_cmd cmd, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_action      <= cmd.action;
        i_digit_index <= cmd.index;
        i_digit_value <= cmd.value;
        do @(posedge i_clk); while (!o_in_ready);
        predict_scan(cmd);
    endtask

    always @(posedge i_clk) begin
        t_scan_word got;
        t_scan_word want;
        out_taken <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_data_bit, o_shift_strobe, o_load_strobe, o_blank_level, o_last};
                if (pending_scan_words.size() == 0) begin
                    note_failure($sformatf("unexpected word data=%b shift=%b load=%b blank=%b last=%b",
                        got.data_bit, got.shift, got.load, got.blank, got.last));
                end else begin
                    want = pending_scan_words.pop_front();
                    if (got !== want) begin
                        note_failure($sformatf({"word %0d mismatch: expected data=%b shift=%b ",
                            "load=%b blank=%b last=%b, got data=%b shift=%b load=%b blank=%b last=%b"},
                            words_checked, want.data_bit, want.shift, want.load, want.blank,
                            want.last, got.data_bit, got.shift, got.load, got.blank, got.last));
                    end
                end
                words_checked++;
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d words still expected",
                    $realtime, IDLE_LIMIT, pending_scan_words.size());
                $display("vfd_digit_scan_serializer_core_test: done, errors");
                $finish;
            end
        end
    end

    // The receiver may stall after each word; in every 120 words it runs at full rate for the first 30.
    always @(negedge i_clk) begin
        int hold;
        if (out_taken) begin
            hold = ((words_checked % 120) < 30) ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
            hold = rx_hold;
        end
        if (hold > 0) begin
            i_out_ready <= 1'b0;
            rx_hold     <= hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            rx_hold     <= 0;
        end
    end

    initial begin
        t_digit_cmd cmd;
        for (int d = 0; d < DIGITS; d++) begin
            digit_patterns[d] = '0;
        end
        scan_pos = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            send_cmd(DIRECTED[k], draw_gap(k + 40));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ((n % 150) == 75) begin
                @(negedge i_clk) i_in_valid <= 1'b0;
                while (pending_scan_words.size() != 0) @(posedge i_clk);
            end
            cmd        = '0;
            cmd.action = ($urandom_range(0, 99) < 45) ? ACT_TICK : ACT_STORE;
            cmd.index  = 2'($urandom_range(0, 3));
            if (cmd.action == ACT_TICK || $urandom_range(0, 4) == 0) begin
                cmd.value = 4'($urandom_range(0, 15));
            end else begin
                cmd.value = 4'($urandom_range(0, 9));
            end
            send_cmd(cmd, draw_gap(n));
        end
        @(negedge i_clk) i_in_valid <= 1'b0;

        while (pending_scan_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d digit stores and %0d refresh ticks; checked %0d serial words,",
            stores_sent, ticks_sent, words_checked);
        $display("with random gaps and stalls on both sides and pauses until the output drained.");
        if (errors == 0) begin
            $display("vfd_digit_scan_serializer_core_test: done, clean");
        end else begin
            $display("vfd_digit_scan_serializer_core_test: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/vdss_pkg.sv
hdl/vdss_front.sv
hdl/vdss_queue.sv
hdl/vdss_back.sv
hdl/vfd_digit_scan_serializer_core.sv
tb/vfd_digit_scan_serializer_core_test.sv
